### design/bfis_pkg.sv
// Shared constants, register codes, controller states, command and status types of the box shrink.
`timescale 1ns / 1ps
package bfis_pkg;

   localparam int FRAC_BITS   = 16;  // fraction bits of a 5.16 factor
   localparam int FACT_W      = 21;
   localparam int SIZE_W      = 13;
   localparam int POS_W       = 12;
   localparam int QUO_W       = 13;
   localparam int M_W         = FACT_W - FRAC_BITS + 1;
   localparam int NP_W        = 2 * M_W;
   localparam int PROD_W      = FACT_W + QUO_W;
   localparam int S_W         = PROD_W - FRAC_BITS;
   localparam int DIV_NUM_W   = SIZE_W + FRAC_BITS;
   localparam int FIELD_W     = 16;
   localparam int FIELD_COUNT = 4;
   localparam int BAND_CNT_W  = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int MAX_SIZE    = 4096;

   localparam int MAX_OUT_WIDTH_DEF = 512;
   localparam int MAX_BANDS_DEF     = 4;
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int MAX_FACTOR_DEF    = 16;

   localparam logic [FACT_W-1:0]     FACTOR_RESET = 21'd131072;
   localparam logic [SIZE_W-1:0]     WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_W-1:0]     HEIGHT_RESET = 13'd480;
   localparam logic [BAND_CNT_W-1:0] BANDS_RESET  = 3'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_FACTOR       = 3'd0,
      CSR_Y_FACTOR       = 3'd1,
      CSR_IN_WIDTH       = 3'd2,
      CSR_IN_HEIGHT      = 3'd3,
      CSR_BAND_COUNT     = 3'd4,
      CSR_SIGNED_SAMPLES = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MULT,
      ST_HITS,
      ST_CELL,
      ST_READ,
      ST_WRITE,
      ST_CHECK,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic       clr_step;
      logic       take_pixel;
      logic       div_start;
      logic       mult_step;
      logic       hit_step;
      logic [1:0] cell_sel;
      logic       mem_rd;
      logic       mem_wr;
      logic       avg_start;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_busy;
      logic cell_ok;
      logic produced;
      logic avg_busy;
      logic out_full;
   } dp_status_type;

endpackage

### design/bfis_div.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
module bfis_div #(
   parameter int NUM_W = 29,
   parameter int DEN_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   sh;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      sh   = {r_ff, q_ff[NUM_W-1]};
      ge   = sh >= {1'b0, d_ff};
      diff = sh - {1'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = num;
         r_in    = '0;
         d_in    = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[NUM_W-2:0], ge};
         r_in   = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;
endmodule

### design/bfis_datapath.sv
// Datapath: configuration, raster position, window search, line banks, averaging and output word.
`timescale 1ns / 1ps
module bfis_datapath #(
   parameter int MAX_OUT_WIDTH = 512,
   parameter int MAX_BANDS     = 4,
   parameter int SAMPLE_BITS   = 16,
   parameter int MAX_FACTOR    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bfis_pkg::dp_cmd_type                 cmd,
   output bfis_pkg::dp_status_type              status,
   input  logic                                 csr_valid,
   input  logic [bfis_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bfis_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [bfis_pkg::FIELD_W*bfis_pkg::FIELD_COUNT-1:0] req_tdata,
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bfis_pkg::FIELD_W*bfis_pkg::FIELD_COUNT-1:0] rsp_tdata,
   output logic                                 rsp_tlast
);
   import bfis_pkg::*;

   localparam int SUM_W  = SAMPLE_BITS + 2 * $clog2(MAX_FACTOR) + 2;
   localparam int AVG_W  = SUM_W + 1;
   localparam int COL_AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
   localparam int DEPTH  = 2 * MAX_OUT_WIDTH;
   localparam int ADDR_W = COL_AW + 1;
   localparam logic [31:0] TOP_FACTOR = 32'(MAX_FACTOR) << FRAC_BITS;
   localparam logic [31:0] ONE_FACTOR = 32'd1 << FRAC_BITS;

   // Configuration registers
   logic [FACT_W-1:0]     xf_reg_ff, yf_reg_ff;
   logic [SIZE_W-1:0]     w_reg_ff, h_reg_ff;
   logic [BAND_CNT_W-1:0] bands_reg_ff;
   logic                  signed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xf_reg_ff    <= FACTOR_RESET;
         yf_reg_ff    <= FACTOR_RESET;
         w_reg_ff     <= WIDTH_RESET;
         h_reg_ff     <= HEIGHT_RESET;
         bands_reg_ff <= BANDS_RESET;
         signed_ff    <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_X_FACTOR:       xf_reg_ff    <= csr_wdata[FACT_W-1:0];
            CSR_Y_FACTOR:       yf_reg_ff    <= csr_wdata[FACT_W-1:0];
            CSR_IN_WIDTH:       w_reg_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_IN_HEIGHT:      h_reg_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_BAND_COUNT:     bands_reg_ff <= csr_wdata[BAND_CNT_W-1:0];
            CSR_SIGNED_SAMPLES: signed_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective configuration after clamping
   logic [FACT_W-1:0]     f_eff [2];   // index 0 is the row axis, 1 the column axis
   logic [M_W-1:0]        m_eff [2];
   logic [SIZE_W-1:0]     w_eff, h_eff;
   logic [BAND_CNT_W-1:0] bands_eff;
   logic [FACT_W:0]       m_sum [2];
   logic [NP_W-1:0]       np;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         logic [FACT_W-1:0] raw;
         raw = (a == 0) ? yf_reg_ff : xf_reg_ff;
         if (32'(raw) < ONE_FACTOR) begin
            f_eff[a] = FACT_W'(ONE_FACTOR);
         end else if (32'(raw) > TOP_FACTOR) begin
            f_eff[a] = TOP_FACTOR[FACT_W-1:0];
         end else begin
            f_eff[a] = raw;
         end
         m_sum[a] = {1'b0, f_eff[a]} + (FACT_W+1)'((32'd1 << FRAC_BITS) - 32'd1);
         m_eff[a] = m_sum[a][FACT_W:FRAC_BITS];
      end
      w_eff = (w_reg_ff == '0) ? SIZE_W'(1) :
              (w_reg_ff > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : w_reg_ff;
      h_eff = (h_reg_ff == '0) ? SIZE_W'(1) :
              (h_reg_ff > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : h_reg_ff;
      bands_eff = (bands_reg_ff == '0) ? BAND_CNT_W'(1) :
                  (bands_reg_ff > BAND_CNT_W'(MAX_BANDS)) ? BAND_CNT_W'(MAX_BANDS) :
                  bands_reg_ff;
      np = NP_W'(m_eff[0]) * NP_W'(m_eff[1]);
   end

   // Raster position and latched pixel
   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [POS_W-1:0] p_ff [2];
   logic [POS_W-1:0] pc, pr;
   logic [SUM_W-1:0] val_ff [MAX_BANDS];

   always_comb begin
      pc = req_tuser ? '0 : col_ff;
      pr = req_tuser ? '0 : row_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.take_pixel) begin
         if ({1'b0, pc} + SIZE_W'(1) >= w_eff) begin
            col_in = '0;
            row_in = ({1'b0, pr} + SIZE_W'(1) >= h_eff) ? '0 : pr + 1'b1;
         end else begin
            col_in = pc + 1'b1;
            row_in = pr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   for (genvar b = 0; b < MAX_BANDS; b++) begin : g_val
      logic [SAMPLE_BITS-1:0] raw;
      logic                   sgn;
      assign raw = req_tdata[FIELD_W*b +: SAMPLE_BITS];
      assign sgn = signed_ff & raw[SAMPLE_BITS-1];
      always_ff @(posedge clock) begin
         if (cmd.take_pixel) begin
            val_ff[b] <= (BAND_CNT_W'(b) < bands_eff) ?
                         {{(SUM_W-SAMPLE_BITS){sgn}}, raw} : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_pixel) begin
         p_ff[0] <= pr;
         p_ff[1] <= pc;
      end
   end

   // Four divisions: last window index touching the pixel per axis, output size per axis
   logic [DIV_NUM_W-1:0] dnum [4];
   logic [FACT_W-1:0]    dden [4];
   logic [DIV_NUM_W-1:0] dquo [4];
   logic [3:0]           dbusy;

   assign dnum[0] = {1'b0, p_ff[0], {FRAC_BITS{1'b1}}};
   assign dnum[1] = {1'b0, p_ff[1], {FRAC_BITS{1'b1}}};
   assign dnum[2] = {h_eff, {FRAC_BITS{1'b0}}};
   assign dnum[3] = {w_eff, {FRAC_BITS{1'b0}}};
   assign dden[0] = f_eff[0];
   assign dden[1] = f_eff[1];
   assign dden[2] = f_eff[0];
   assign dden[3] = f_eff[1];

   for (genvar i = 0; i < 4; i++) begin : g_pos_div
      bfis_div #(.NUM_W(DIV_NUM_W), .DEN_W(FACT_W)) u_div (
         .clock (clock),
         .reset (reset),
         .start (cmd.div_start),
         .num   (dnum[i]),
         .den   (dden[i]),
         .busy  (dbusy[i]),
         .quot  (dquo[i])
      );
   end

   // Candidate windows and their start products
   logic [QUO_W-1:0]  cnt_ff [2];
   logic [QUO_W-1:0]  k_ff   [2][2];
   logic              kv_ff  [2][2];
   logic [PROD_W-1:0] prod_ff [2][2];

   always_ff @(posedge clock) begin
      if (cmd.mult_step) begin
         for (int a = 0; a < 2; a++) begin
            logic [QUO_W-1:0] cnt, hi;
            cnt = dquo[a+2][QUO_W-1:0];
            if (a == 1 && cnt > QUO_W'(MAX_OUT_WIDTH)) begin
               cnt = QUO_W'(MAX_OUT_WIDTH);
            end
            hi = dquo[a][QUO_W-1:0];
            if (cnt != '0 && hi > cnt - 1'b1) begin
               hi = cnt - 1'b1;
            end
            cnt_ff[a]     <= cnt;
            k_ff[a][0]    <= hi - 1'b1;
            k_ff[a][1]    <= hi;
            kv_ff[a][0]   <= (cnt != '0) && (hi != '0);
            kv_ff[a][1]   <= (cnt != '0);
            prod_ff[a][0] <= PROD_W'(hi - 1'b1) * PROD_W'(f_eff[a]);
            prod_ff[a][1] <= PROD_W'(hi) * PROD_W'(f_eff[a]);
         end
      end
   end

   // Window hits
   logic             hv_ff [2][2];
   logic             hf_ff [2][2];
   logic             hl_ff [2][2];
   logic [QUO_W-1:0] hidx_ff [2][2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 2; a++) begin
            for (int j = 0; j < 2; j++) begin
               hv_ff[a][j] <= 1'b0;
            end
         end
      end else if (cmd.hit_step) begin
         for (int a = 0; a < 2; a++) begin
            for (int j = 0; j < 2; j++) begin
               logic [S_W-1:0] s, p;
               logic [S_W:0]   send;
               s    = prod_ff[a][j][PROD_W-1:FRAC_BITS];
               p    = S_W'(p_ff[a]);
               send = {1'b0, s} + (S_W+1)'(m_eff[a]);
               hv_ff[a][j] <= kv_ff[a][j] && (p >= s) && ({1'b0, p} < send);
               hf_ff[a][j] <= (p == s);
               hl_ff[a][j] <= ({1'b0, p} == send - 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hit_step) begin
         for (int a = 0; a < 2; a++) begin
            for (int j = 0; j < 2; j++) begin
               hidx_ff[a][j] <= k_ff[a][j];
            end
         end
      end
   end

   // Selected cell
   logic              rsel, csel;
   logic              cell_start, cell_done;
   logic [ADDR_W-1:0] cell_addr;

   assign rsel       = cmd.cell_sel[1];
   assign csel       = cmd.cell_sel[0];
   assign cell_start = hf_ff[0][rsel] & hf_ff[1][csel];
   assign cell_done  = hl_ff[0][rsel] & hl_ff[1][csel];
   assign cell_addr  = {hidx_ff[0][rsel][0], hidx_ff[1][csel][COL_AW-1:0]};

   // Line banks, cleared once after reset
   logic [MAX_BANDS*SUM_W-1:0] mem [DEPTH];
   logic [MAX_BANDS*SUM_W-1:0] rd_ff;
   logic [MAX_BANDS*SUM_W-1:0] new_sum;
   logic [ADDR_W-1:0]          clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   for (genvar b = 0; b < MAX_BANDS; b++) begin : g_acc
      assign new_sum[SUM_W*b +: SUM_W] = cell_start ? val_ff[b] :
                                         rd_ff[SUM_W*b +: SUM_W] + val_ff[b];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         mem[clr_ff] <= '0;
      end else if (cmd.mem_wr) begin
         mem[cell_addr] <= new_sum;
      end
      if (cmd.mem_rd) begin
         rd_ff <= mem[cell_addr];
      end
   end

   // Completed window capture
   logic                       produced_ff;
   logic [MAX_BANDS*SUM_W-1:0] cap_ff;
   logic                       fe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         produced_ff <= 1'b0;
      end else if (cmd.take_pixel) begin
         produced_ff <= 1'b0;
      end else if (cmd.mem_wr && cell_done) begin
         produced_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr && cell_done && !produced_ff) begin
         cap_ff <= new_sum;
         fe_ff  <= (hidx_ff[0][rsel] == cnt_ff[0] - 1'b1) &&
                   (hidx_ff[1][csel] == cnt_ff[1] - 1'b1);
      end
   end

   // Rounded mean per band: (sum + np/2) / np, truncating toward zero
   logic [MAX_BANDS-1:0] abusy;
   logic [SAMPLE_BITS-1:0] mean [MAX_BANDS];

   for (genvar b = 0; b < MAX_BANDS; b++) begin : g_avg
      logic signed [AVG_W-1:0] num;
      logic [AVG_W-1:0]        mag;
      logic [AVG_W-1:0]        q;
      logic [AVG_W-1:0]        qs;
      logic                    neg_ff;
      assign num = AVG_W'($signed(cap_ff[SUM_W*b +: SUM_W])) + AVG_W'(np >> 1);
      assign mag = num[AVG_W-1] ? AVG_W'(-num) : AVG_W'(num);
      always_ff @(posedge clock) begin
         if (cmd.avg_start) begin
            neg_ff <= num[AVG_W-1];
         end
      end
      bfis_div #(.NUM_W(AVG_W), .DEN_W(NP_W)) u_div (
         .clock (clock),
         .reset (reset),
         .start (cmd.avg_start),
         .num   (mag),
         .den   (np),
         .busy  (abusy[b]),
         .quot  (q)
      );
      assign qs      = neg_ff ? AVG_W'(-q) : q;
      assign mean[b] = (BAND_CNT_W'(b) < bands_eff) ? qs[SAMPLE_BITS-1:0] : '0;
   end

   // Output word register
   logic                               out_valid_ff;
   logic [FIELD_W*FIELD_COUNT-1:0]     out_data_ff, out_data_in;
   logic                               out_last_ff;

   always_comb begin
      out_data_in = '0;
      for (int b = 0; b < MAX_BANDS; b++) begin
         out_data_in[FIELD_W*b +: FIELD_W] = FIELD_W'(mean[b]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_data_ff <= out_data_in;
         out_last_ff <= fe_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   assign status.clr_last = (clr_ff == ADDR_W'(DEPTH - 1));
   assign status.div_busy = |dbusy;
   assign status.cell_ok  = hv_ff[0][rsel] & hv_ff[1][csel];
   assign status.produced = produced_ff;
   assign status.avg_busy = |abusy;
   assign status.out_full = out_valid_ff & ~rsp_tready;
endmodule

### design/bfis_ctrl.sv
// Controller: sequences clearing, window search, cell updates, averaging and output.
`timescale 1ns / 1ps
module bfis_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  bfis_pkg::dp_status_type status,
   output bfis_pkg::dp_cmd_type    cmd
);
   import bfis_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [1:0]     cell_ff, cell_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cell_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cell_ff  <= cell_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cell_in      = cell_ff;
      cmd          = '0;
      cmd.cell_sel = cell_ff;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take_pixel = 1'b1;
               state_in       = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult_step = 1'b1;
            state_in      = ST_HITS;
         end
         ST_HITS: begin
            cmd.hit_step = 1'b1;
            cell_in      = '0;
            state_in     = ST_CELL;
         end
         ST_CELL: begin
            if (status.cell_ok) begin
               state_in = ST_READ;
            end else if (cell_ff == 2'd3) begin
               state_in = ST_CHECK;
            end else begin
               cell_in = cell_ff + 1'b1;
            end
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.mem_wr = 1'b1;
            if (cell_ff == 2'd3) begin
               state_in = ST_CHECK;
            end else begin
               cell_in  = cell_ff + 1'b1;
               state_in = ST_CELL;
            end
         end
         ST_CHECK: begin
            state_in = status.produced ? ST_AVG_START : ST_IDLE;
         end
         ST_AVG_START: begin
            cmd.avg_start = 1'b1;
            state_in      = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (!status.avg_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!status.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

### design/box_filter_image_shrink.sv
// Top level of the streaming box-filter shrink: controller, datapath and checks.
//
//   channel  dir  handshake                word
//   req_     in   req_tvalid/req_tready    tdata: band0..band3, tuser: frame_start
//   rsp_     out  rsp_tvalid/rsp_tready    tdata: out_band0..out_band3, tlast: frame_end
//   csr_     in   csr_valid/csr_ready      csr_index, csr_wdata
//
// A pixel that closes no window runs through the position dividers; one that closes a window
// also runs through the per-band average dividers. The 29-step position dividers and the
// per-band average dividers retire one quotient bit a cycle each.
// After reset a clearing pass over all 2*MAX_OUT_WIDTH words zeroes the line banks; no pixel
// is taken meanwhile. A finished word waits in the output register while the next pixel
// is taken; a stalled rsp_tready holds the controller only when a second word is ready.
`timescale 1ns / 1ps
module box_filter_image_shrink #(
   parameter int MAX_OUT_WIDTH = bfis_pkg::MAX_OUT_WIDTH_DEF,
   parameter int MAX_BANDS     = bfis_pkg::MAX_BANDS_DEF,
   parameter int SAMPLE_BITS   = bfis_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_FACTOR    = bfis_pkg::MAX_FACTOR_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // band0 [15:0], band1 [31:16], band2 [47:32], band3 [63:48]
   input  logic [bfis_pkg::FIELD_W*bfis_pkg::FIELD_COUNT-1:0] req_tdata,
   // frame_start
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_band0 [15:0], out_band1 [31:16], out_band2 [47:32], out_band3 [63:48]
   output logic [bfis_pkg::FIELD_W*bfis_pkg::FIELD_COUNT-1:0] rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bfis_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bfis_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bfis_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   bfis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bfis_datapath #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .MAX_BANDS     (MAX_BANDS),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .MAX_FACTOR    (MAX_FACTOR)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // One pixel at a time: intake closes right after a word is taken.
   a_one_pixel: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("pixel taken while previous pixel still in work");

   // A new result never overwrites a word that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_tvalid && !rsp_tready))
      else $error("output word overwritten");

   // The clearing pass and pixel intake exclude each other.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !req_tready && !cmd.mem_wr)
      else $error("line bank access during clearing pass");
`endif
endmodule
